### hw/rtl/qte_pkg.sv
// Shared types, widths, constants and helpers for the quaternion to Euler angle block.
// Used by qte_isqrt, qte_cordic and quaternion_to_euler_angles_top.
// No dependencies.
package qte_pkg;

    // Operand width of the atan2 inputs (Q.28 sums and differences, with headroom).
    localparam int OPW = 35;
    // Width of the CORDIC vector coordinates (growth and pre-rotation headroom).
    localparam int CW = 38;
    // Width of the Q.30 angle accumulator.
    localparam int AW = 34;
    // Width of the square-root radicand (values up to 2^56) and its running root.
    localparam int SQ_W = 57;
    localparam int RT_W = 58;
    // One result bit is produced per square-root step.
    localparam int SQRT_STEPS = 29;
    // Largest CORDIC depth the arctangent table supports.
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [OPW-1:0] ONE_Q28 = 35'sd268435456;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [16:0] ANGLE_MAX_Q13 = 17'sd25736;

    // Register index of the reprojection mode bit.
    localparam logic REG_REPROJECT = 1'b0;

    // atan(2^-i) in Q.30, truncated.
    localparam logic signed [AW-1:0] ATAN_Q30 [ATAN_LEN] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
    };

    // Operands that travel alongside the square-root pipeline.
    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic signed [OPW-1:0] rnum;
        logic signed [OPW-1:0] rden;
        logic signed [OPW-1:0] pnum;
        logic signed [OPW-1:0] pden;
        logic signed [OPW-1:0] ynum;
        logic signed [OPW-1:0] yden;
    } qte_ops_t;

    // Round a Q.30 angle to Q3.13 and saturate to plus or minus pi.
    function automatic logic [15:0] to_q13(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] s;
        logic signed [AW-18:0] r;
        begin
            s = a + AW'(65536);
            r = (AW-17)'(s >>> 17);
            if (r > ANGLE_MAX_Q13) begin
                r = ANGLE_MAX_Q13;
            end else if (r < -ANGLE_MAX_Q13) begin
                r = -ANGLE_MAX_Q13;
            end
            return r[15:0];
        end
    endfunction

endpackage

### hw/rtl/quaternion_to_euler_angles_top.sv
// Channel   Dir  Ports                    Beat contents
// s_        in   s_tvalid/s_tready/tdata  quat_x, quat_y, quat_z, quat_w (Q2.14 each)
// m_        out  m_tvalid/m_tready/tdata  roll_angle, pitch_angle, yaw_angle (Q3.13 each)
// APB       in   psel/penable/pwrite/...  reproject_axis at byte address 0
//
// One beat is accepted per cycle while m_tready does not stall the output; the pipeline
// consists of four arithmetic stages, the 29-step square root, the CORDIC
// entry register and stages, and the output register.
// Reset (aresetn low, synchronous) clears all valid bits and sets reproject_axis to 1.
// A stall on m_tready holds the whole pipeline; s_tready drops in the same cycle.
// Depends on qte_pkg, qte_isqrt and qte_cordic.
module quaternion_to_euler_angles_top
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: quat_x [15:0], quat_y [31:16], quat_z [47:32], quat_w [63:48]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // m_tdata: roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NST = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    logic en;
    logic mode_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_REPROJECT)) begin
            mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REPROJECT) ? {31'b0, mode_reg} : '0;

    // The pipeline moves whenever the output register is free or being drained.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: all component products.
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg, xy_reg;
    logic signed [31:0] xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic               v1_reg;
    logic               m1_reg;

    assign qx = s_tdata[15:0];
    assign qy = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg <= mode_reg;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            ww_reg <= qw * qw;
            xy_reg <= qx * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
            wy_reg <= qw * qy;
            wz_reg <= qw * qz;
        end
    end

    // Stage 2: sums, mode selection and the clamped sine term.
    logic signed [OPW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
    logic signed [OPW-1:0] sv;
    qte_ops_t              ops2_next, ops2_reg;
    logic [28:0]           vabs2_next, vabs2_reg;

    always_comb begin
        exx = OPW'(xx_reg);
        eyy = OPW'(yy_reg);
        ezz = OPW'(zz_reg);
        eww = OPW'(ww_reg);
        exy = OPW'(xy_reg);
        exz = OPW'(xz_reg);
        eyz = OPW'(yz_reg);
        ewx = OPW'(wx_reg);
        ewy = OPW'(wy_reg);
        ewz = OPW'(wz_reg);

        sv = (ewy - exz) <<< 1;
        if (sv > ONE_Q28) begin
            sv = ONE_Q28;
        end else if (sv < -ONE_Q28) begin
            sv = -ONE_Q28;
        end
        vabs2_next = (sv < 0) ? 29'(-sv) : 29'(sv);

        ops2_next.valid = v1_reg;
        ops2_next.mode  = m1_reg;
        ops2_next.rnum  = (exy + ewz) <<< 1;
        ops2_next.pnum  = (eyz + ewx) <<< 1;
        ops2_next.yden  = ONE_Q28 - ((exx + eyy) <<< 1);
        if (m1_reg) begin
            ops2_next.rden = ONE_Q28 - ((eyy + ezz) <<< 1);
            ops2_next.pden = ONE_Q28 - ((exx + ezz) <<< 1);
            ops2_next.ynum = (exz + ewy) <<< 1;
        end else begin
            ops2_next.rden = eww + exx - eyy - ezz;
            ops2_next.pden = eww - exx - eyy + ezz;
            ops2_next.ynum = sv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ops2_reg.valid <= 1'b0;
        end else if (en) begin
            ops2_reg <= ops2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vabs2_reg <= vabs2_next;
        end
    end

    // Stage 3: partial products of the squared sine term.
    qte_ops_t    ops3_reg;
    logic [29:0] aa3_reg;
    logic [28:0] ab3_reg;
    logic [27:0] bb3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ops3_reg.valid <= 1'b0;
        end else if (en) begin
            ops3_reg <= ops2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            aa3_reg <= 30'(vabs2_reg[28:14]) * 30'(vabs2_reg[28:14]);
            ab3_reg <= 29'(vabs2_reg[28:14]) * 29'(vabs2_reg[13:0]);
            bb3_reg <= 28'(vabs2_reg[13:0]) * 28'(vabs2_reg[13:0]);
        end
    end

    // Stage 4: radicand of the cosine term, one minus the square.
    qte_ops_t        ops4_reg;
    logic [SQ_W-1:0] sq4_reg;
    logic [SQ_W-1:0] vsq;

    assign vsq = (SQ_W'(aa3_reg) << 28) + (SQ_W'(ab3_reg) << 15) + SQ_W'(bb3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ops4_reg.valid <= 1'b0;
        end else if (en) begin
            ops4_reg <= ops3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq4_reg <= (SQ_W'(1) << 56) - vsq;
        end
    end

    // Square root, with the other operands delayed to match.
    logic [28:0] root;
    qte_ops_t    dly_reg [SQRT_STEPS];

    qte_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sq4_reg),
        .root     (root)
    );

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_dly
        qte_ops_t src;

        if (k == 0) begin : g_first
            assign src = ops4_reg;
        end else begin : g_rest
            assign src = dly_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dly_reg[k].valid <= 1'b0;
            end else if (en) begin
                dly_reg[k] <= src;
            end
        end
    end

    // Three arctangent pipelines; yaw takes the root as its cosine in direct mode.
    qte_ops_t              opsq;
    logic signed [OPW-1:0] yden_sel;
    logic signed [AW-1:0]  roll_ang, pitch_ang, yaw_ang;

    assign opsq     = dly_reg[SQRT_STEPS-1];
    assign yden_sel = opsq.mode ? opsq.yden : OPW'(root);

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .aclk (aclk),
        .en   (en),
        .num  (opsq.rnum),
        .den  (opsq.rden),
        .ang  (roll_ang)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .aclk (aclk),
        .en   (en),
        .num  (opsq.pnum),
        .den  (opsq.pden),
        .ang  (pitch_ang)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .aclk (aclk),
        .en   (en),
        .num  (opsq.ynum),
        .den  (yden_sel),
        .ang  (yaw_ang)
    );

    // Valid bits alongside the CORDIC stages.
    logic vc_reg [NST+1];

    for (genvar i = 0; i <= NST; i++) begin : g_vc
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_reg[i] <= 1'b0;
            end else if (en) begin
                vc_reg[i] <= (i == 0) ? opsq.valid : vc_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // Output register: rounding and saturation to Q3.13.
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vc_reg[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {to_q13(yaw_ang), to_q13(pitch_ang), to_q13(roll_ang)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/qte_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on qte_pkg.
module qte_isqrt
    import qte_pkg::*;
(
    input  logic            aclk,
    input  logic            en,
    input  logic [SQ_W-1:0] radicand,
    output logic [28:0]     root
);

    logic [SQ_W-1:0] n_reg [SQRT_STEPS];
    logic [RT_W-1:0] r_reg [SQRT_STEPS];

    // Each step tries the next bit pair of the radicand.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam int SH = SQ_W - 1 - 2 * k;
        logic [RT_W-1:0] bit_val;
        logic [RT_W-1:0] n_in;
        logic [RT_W-1:0] r_in;
        logic [RT_W-1:0] trial;
        logic [SQ_W-1:0] n_next;
        logic [RT_W-1:0] r_next;

        if (k == 0) begin : g_first
            assign n_in = RT_W'(radicand);
            assign r_in = '0;
        end else begin : g_rest
            assign n_in = RT_W'(n_reg[k-1]);
            assign r_in = r_reg[k-1];
        end

        always_comb begin
            bit_val = RT_W'(1) << SH;
            trial = r_in + bit_val;
            if (n_in >= trial) begin
                n_next = SQ_W'(n_in - trial);
                r_next = (r_in >> 1) + bit_val;
            end else begin
                n_next = SQ_W'(n_in);
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][28:0];

endmodule

### hw/rtl/qte_cordic.sv
// Pipelined vectoring CORDIC that returns atan2(num, den) in Q.30 radians.
// Depends on qte_pkg.
module qte_cordic
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [OPW-1:0] num,
    input  logic signed [OPW-1:0] den,
    output logic signed [AW-1:0]  ang
);

    localparam int NST = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    logic signed [CW-1:0] px_reg  [NST+1];
    logic signed [CW-1:0] py_reg  [NST+1];
    logic signed [AW-1:0] ang_reg [NST+1];
    logic                 zf_reg  [NST+1];

    logic signed [CW-1:0] px0;
    logic signed [CW-1:0] py0;
    logic signed [AW-1:0] a0;

    // Points in the left half plane are turned by a quarter turn first.
    always_comb begin
        if (den < 0) begin
            if (num >= 0) begin
                px0 = CW'(num);
                py0 = -CW'(den);
                a0  = HALF_PI_Q30;
            end else begin
                px0 = -CW'(num);
                py0 = CW'(den);
                a0  = -HALF_PI_Q30;
            end
        end else begin
            px0 = CW'(den);
            py0 = CW'(num);
            a0  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0]  <= px0;
            py_reg[0]  <= py0;
            ang_reg[0] <= a0;
            zf_reg[0]  <= (num == '0) && (den == '0);
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < NST; i++) begin : g_stage
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = py_reg[i] >>> i;
        assign dy = px_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                zf_reg[i+1] <= zf_reg[i];
                if (py_reg[i] > 0) begin
                    px_reg[i+1]  <= px_reg[i] + dx;
                    py_reg[i+1]  <= py_reg[i] - dy;
                    ang_reg[i+1] <= ang_reg[i] + ATAN_Q30[i];
                end else begin
                    px_reg[i+1]  <= px_reg[i] - dx;
                    py_reg[i+1]  <= py_reg[i] + dy;
                    ang_reg[i+1] <= ang_reg[i] - ATAN_Q30[i];
                end
            end
        end
    end

    // Both operands zero gives an angle of zero.
    assign ang = zf_reg[NST] ? '0 : ang_reg[NST];

endmodule

### hw/rtl/qte_checker.sv
// Port-level checks for quaternion_to_euler_angles_top, attached by bind.
// Depends on the top level's port list only.
module qte_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A stalled output blocks the input side in the same cycle.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // Roll stays within plus or minus pi.
    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736)
                  && ($signed(m_tdata[15:0]) >= -16'sd25736))
        else $error("roll out of range");

    // No result is shown right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);
